### rtl/core/stw_pkg.sv
// Package for the scrolling text window: shared constants, payload structs,
// configuration register codes and the sequencer state type. No dependencies.
package stw_pkg;

  localparam int TEXT_DEPTH_DEF = 64;
  localparam int WINDOW_MAX_DEF = 32;

  localparam int CHAR_W     = 8;
  localparam int POS_W      = 5;
  localparam int PERIOD_W   = 16;
  localparam int WLEN_W     = 6;
  localparam int ELAPSED_W  = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd200;
  localparam logic [WLEN_W-1:0]   WLEN_RST   = 6'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_MS  = 1'b0,
    CFG_WINDOW_LEN = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    func_e             func;
    logic [CHAR_W-1:0] text_char;
    logic              text_end;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  window_pos;
    logic [CHAR_W-1:0] window_char;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_ms;
    logic [WLEN_W-1:0]   window_len;
  } cfg_t;

endpackage

### rtl/core/scrolling_text_window.sv
// Top level of the scrolling text window: configuration registers and the
// wiring of stw_ctrl to the stw_text_mem text store. Depends on stw_pkg.
//
// Usage. Input transactions carry either one text character (func = load)
// or a one-millisecond tick (func = tick). A load that follows a finished
// text starts a new one; a zero byte or the text_end flag closes the text,
// and characters beyond TEXT_DEPTH - 1 are dropped. Loads and ticks that do
// not trigger a scroll step produce no output. When a tick pushes the
// elapsed count past period_ms, the start position advances by one
// (wrapping at the text length) and the block streams a run of window_len
// characters, capped at WINDOW_MAX, on the output channel, one transaction
// each, with window_pos counting from zero and last set on the final one.
// Throughput: after the tick is taken the input stays stalled during the run;
// the single read port of the text store delivers one character per cycle,
// so the first character passes the state register, the read stage and the
// output register, and the rest follow back to back when not stalled.
// A stall on the output freezes the output register and the read stage;
// nothing is lost and the run resumes where it stopped. The input side is
// taken again as soon as the last read of a run has moved into the output
// register. Reset clears all control state, sets period_ms to 200 and
// window_len to 16; the text store itself is not cleared. Configuration
// writes take effect on the next edge and are meant for idle periods.
module scrolling_text_window #(
  parameter int TEXT_DEPTH = stw_pkg::TEXT_DEPTH_DEF,
  parameter int WINDOW_MAX = stw_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  stw_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output stw_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [stw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stw_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(TEXT_DEPTH);

  stw_pkg::cfg_t cfg_q, cfg_d;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [stw_pkg::CHAR_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [stw_pkg::CHAR_W-1:0] mem_rdata;

  // Register writes keep only the low bits that each register holds.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (stw_pkg::cfg_idx_e'(cfg_idx_i))
        stw_pkg::CFG_PERIOD_MS:  cfg_d.period_ms  = cfg_wdata_i[stw_pkg::PERIOD_W-1:0];
        stw_pkg::CFG_WINDOW_LEN: cfg_d.window_len = cfg_wdata_i[stw_pkg::WLEN_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ms  <= stw_pkg::PERIOD_RST;
      cfg_q.window_len <= stw_pkg::WLEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  stw_ctrl #(
    .TEXT_DEPTH(TEXT_DEPTH),
    .WINDOW_MAX(WINDOW_MAX),
    .AW        (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // Loads and reads never overlap: the input is stalled during a run.
  stw_text_mem #(
    .DEPTH(TEXT_DEPTH),
    .AW   (AW),
    .DW   (stw_pkg::CHAR_W)
  ) u_text_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

### rtl/core/stw_text_mem.sv
// Text store of the scrolling text window: one write port, one read port
// with registered read data. Depends on nothing but its parameters.
module stw_text_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a stalled consumer loses nothing.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/stw_ctrl.sv
// Control of the scrolling text window: load bookkeeping, tick counter,
// scroll step and the read sequencer that streams one window run.
// Depends on stw_pkg; drives the ports of stw_text_mem.
module stw_ctrl #(
  parameter int TEXT_DEPTH = stw_pkg::TEXT_DEPTH_DEF,
  parameter int WINDOW_MAX = stw_pkg::WINDOW_MAX_DEF,
  parameter int AW         = $clog2(TEXT_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stw_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  stw_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output stw_pkg::out_item_t        out_data_o,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [stw_pkg::CHAR_W-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [stw_pkg::CHAR_W-1:0] mem_rdata_i
);

  localparam int NW = $clog2(WINDOW_MAX + 1);
  localparam logic [AW-1:0] LEN_CAP = AW'(TEXT_DEPTH - 1);

  stw_pkg::ctrl_state_e state_q, state_d;

  logic [AW-1:0]                   len_q, len_d;
  logic                            loading_q, loading_d;
  logic [AW-1:0]                   start_q, start_d;
  logic [stw_pkg::ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic [AW-1:0]                   idx_q, idx_d;
  logic [NW-1:0]                   k_q, k_d;
  logic [NW-1:0]                   cnt_q, cnt_d;
  logic                            pend_q, pend_d;
  logic [stw_pkg::POS_W-1:0]       pend_pos_q;
  logic                            pend_last_q;
  logic                            out_valid_q, out_valid_d;
  stw_pkg::out_item_t              out_data_q;

  logic                            in_acc;
  logic                            is_load;
  logic                            is_tick;
  logic [AW-1:0]                   len_base;
  logic                            store_char;
  logic [stw_pkg::ELAPSED_W-1:0]   elapsed_inc;
  logic                            fire;
  logic [AW:0]                     step;
  logic [AW-1:0]                   start_next;
  logic [NW-1:0]                   win_n;
  logic                            advance;
  logic                            issue;
  logic [AW:0]                     idx_inc;
  logic [AW-1:0]                   idx_next;

  assign in_stall_o = (state_q == stw_pkg::ST_RUN) || pend_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_load    = in_acc && (in_data_i.func == stw_pkg::FUNC_LOAD);
  assign is_tick    = in_acc && (in_data_i.func == stw_pkg::FUNC_TICK);

  // A load while no text is open starts a new text at length zero.
  assign len_base   = loading_q ? len_q : '0;
  assign store_char = is_load && (in_data_i.text_char != '0) && (len_base < LEN_CAP);

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign fire        = elapsed_inc > {1'b0, cfg_i.period_ms};
  assign step        = {1'b0, start_q} + 1'b1;
  assign start_next  = (step >= {1'b0, len_q}) ? '0 : step[AW-1:0];
  assign win_n       = (int'(cfg_i.window_len) > WINDOW_MAX) ? NW'(WINDOW_MAX)
                                                             : NW'(cfg_i.window_len);

  assign advance  = pend_q && (!out_valid_q || !out_stall_i);
  assign idx_inc  = {1'b0, idx_q} + 1'b1;
  assign idx_next = (idx_inc >= {1'b0, len_q}) ? '0 : idx_inc[AW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stw_pkg::ST_IDLE: begin
        if (is_tick && fire && (win_n != '0)) begin
          state_d = stw_pkg::ST_RUN;
        end
      end
      stw_pkg::ST_RUN: begin
        if (issue && (cnt_q == NW'(1))) begin
          state_d = stw_pkg::ST_IDLE;
        end
      end
      default: state_d = stw_pkg::ST_IDLE;
    endcase
  end

  // State outputs: one read per cycle while running and the read stage has room.
  always_comb begin
    issue = 1'b0;
    unique case (state_q)
      stw_pkg::ST_IDLE: issue = 1'b0;
      stw_pkg::ST_RUN:  issue = !pend_q || advance;
      default:          issue = 1'b0;
    endcase
  end

  assign mem_re_o    = issue;
  assign mem_raddr_o = idx_q;
  assign mem_we_o    = store_char;
  assign mem_waddr_o = len_base;
  assign mem_wdata_o = in_data_i.text_char;

  // Datapath next values.
  always_comb begin
    len_d       = len_q;
    loading_d   = loading_q;
    start_d     = start_q;
    elapsed_d   = elapsed_q;
    idx_d       = idx_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;

    if (is_load) begin
      len_d     = store_char ? len_base + 1'b1 : len_base;
      loading_d = !((in_data_i.text_char == '0) || in_data_i.text_end);
    end

    if (is_tick) begin
      if (fire) begin
        elapsed_d = '0;
        start_d   = start_next;
        idx_d     = start_next;
        cnt_d     = win_n;
        k_d       = '0;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end

    if (issue) begin
      idx_d = idx_next;
      cnt_d = cnt_q - 1'b1;
      k_d   = k_q + 1'b1;
    end

    if (issue) begin
      pend_d = 1'b1;
    end else if (advance) begin
      pend_d = 1'b0;
    end

    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stw_pkg::ST_IDLE;
      len_q       <= '0;
      loading_q   <= 1'b0;
      start_q     <= '0;
      elapsed_q   <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      loading_q   <= loading_d;
      start_q     <= start_d;
      elapsed_q   <= elapsed_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Tags that travel alongside the outstanding memory read.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_pos_q  <= stw_pkg::POS_W'(k_q);
      pend_last_q <= (cnt_q == NW'(1));
    end
  end

  // An empty text shows zero bytes; the text cannot change during a run.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.window_pos  <= pend_pos_q;
      out_data_q.window_char <= (len_q == '0) ? '0 : mem_rdata_i;
      out_data_q.last        <= pend_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/stw_checker.sv
// Port-level checks for the scrolling text window, bound to the top level.
// Depends on stw_pkg and the scrolling_text_window port list.
module stw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input stw_pkg::out_item_t             out_data_o
);

  // A held output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output payload changed while stalled");

  // Inside a run the next character is ready right after one is taken.
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a window run");

  // Window positions count up by one within a run.
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      out_data_o.window_pos == $past(out_data_o.window_pos) + 5'd1)
    else $error("window position did not advance by one");

  // No new input is taken while a run is still being delivered.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input accepted in the middle of a run");

endmodule

bind scrolling_text_window stw_checker u_stw_checker (.*);
